### rtl/mfdl_pkg.sv
// Shared constants for the modulated fractional delay line.
package mfdl_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int OFFSET_W = 21;
    localparam int CH_W     = 1;
    localparam int BASE_W   = 12;

    // Stream bus widths (tdata padded to whole bytes)
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes (paddr[APB_ADDR_W-1:2])
    localparam logic [APB_ADDR_W-3:0] REG_BASE_DELAY = '0;

    localparam logic [BASE_W-1:0] BASE_DELAY_RST = BASE_W'(1);

    // Parameter defaults
    localparam int BUFFER_DEPTH_DEF = 4096;
    localparam int CHANNELS_DEF     = 2;
    localparam int FRAC_BITS_DEF    = 8;

endpackage

### rtl/modulated_fractional_delay_line.sv
// Top level: multichannel circular delay line with linearly interpolated modulated read.
// Pipeline: six register stages (input, remainder, offset, store read, blend, result).
// Throughput: one transaction per cycle in each direction while m_tready is high, as the
//   sample store serves both reads and the write of an item together.
// Reset: control clears at once; the sample store is then swept to zero one entry per
//   cycle, all CHANNELS*BUFFER_DEPTH entries (8192 by default), with s_tready low meanwhile.
// Configuration writes are accepted during the sweep.
module modulated_fractional_delay_line #(
    parameter int BUFFER_DEPTH = mfdl_pkg::BUFFER_DEPTH_DEF,
    parameter int CHANNELS     = mfdl_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS    = mfdl_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mfdl_pkg::IN_TDATA_W-1:0]   s_tdata,   // [23:0] in_sample, [44:24] mod_offset
    input  logic                              s_tlast,   // frame_end
    input  logic [mfdl_pkg::CH_W-1:0]         s_tuser,   // [0] channel
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfdl_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [23:0] out_sample
    output logic [mfdl_pkg::CH_W-1:0]         m_tuser,   // [0] out_channel
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfdl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mfdl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mfdl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mfdl_pkg::*;

    // Store geometry: one row of BUFFER_DEPTH entries per channel.
    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int TOTAL  = CHANNELS * BUFFER_DEPTH;
    localparam int MAW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CLR_W  = $clog2(TOTAL + 1);

    // Integer part of the offset and its reduction modulo the depth.
    // q = floor(v * RECIP / 2^IPW) is the true quotient or one less,
    // so the remainder is below twice the depth and one subtract fixes it.
    localparam int IPW    = OFFSET_W - 1 - FRAC_BITS;
    localparam int RECIP  = (2 ** IPW) / BUFFER_DEPTH;
    localparam int QD_W   = IPW + AW + 1;

    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int ACC_W  = SAMPLE_W + FRAC_BITS + 3;

    localparam int OFS_LSB = SAMPLE_W;

    // ---------------------------------------------------------------------
    // Modular subtract on store indexes
    // ---------------------------------------------------------------------
    function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (t[AW])
        begin
            t = t + (AW+1)'(BUFFER_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    logic [BASE_W-1:0] base_delay_reg, base_delay_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              clear_done;

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
    logic in_accept;
    logic mem_go;
    logic cfg_wr;

    // ---------------------------------------------------------------------
    // Pipeline payload
    // ---------------------------------------------------------------------
    // stage 1: captured input, offset split, reciprocal product
    logic [CH_W-1:0]      p1_ch_reg;
    logic                 p1_ch_ok_reg;
    logic [SAMPLE_W-1:0]  p1_sample_reg;
    logic [FRAC_BITS-1:0] p1_frac_reg;
    logic                 p1_fend_reg;
    logic [IPW-1:0]       p1_v_reg;
    logic [IPW-1:0]       p1_q_reg;
    // stage 2: raw remainder
    logic [CH_W-1:0]      p2_ch_reg;
    logic                 p2_ch_ok_reg;
    logic [SAMPLE_W-1:0]  p2_sample_reg;
    logic [FRAC_BITS-1:0] p2_frac_reg;
    logic                 p2_fend_reg;
    logic [AW:0]          p2_rem_reg;
    // stage 3: integer offset modulo depth
    logic [CH_W-1:0]      p3_ch_reg;
    logic                 p3_ch_ok_reg;
    logic [SAMPLE_W-1:0]  p3_sample_reg;
    logic [FRAC_BITS-1:0] p3_frac_reg;
    logic                 p3_fend_reg;
    logic [AW-1:0]        p3_ipart_reg;
    // stage 4: store read data
    logic [CH_W-1:0]      p4_ch_reg;
    logic                 p4_ch_ok_reg;
    logic [FRAC_BITS-1:0] p4_frac_reg;
    logic [SAMPLE_W-1:0]  p4_rd0_reg;
    logic [SAMPLE_W-1:0]  p4_rd1_reg;
    // stage 5: blend product
    logic [CH_W-1:0]         p5_ch_reg;
    logic                    p5_ch_ok_reg;
    logic signed [SAMPLE_W-1:0] p5_s0_reg;
    logic signed [PROD_W-1:0]   p5_prod_reg;
    // result register
    logic [SAMPLE_W-1:0]  out_sample_reg;
    logic [CH_W-1:0]      out_ch_reg;

    // combinational next values
    logic [OFFSET_W-2:0]  um;
    logic [2*IPW-1:0]     q_prod;
    logic [IPW-1:0]       p1_v_next, p1_q_next;
    logic                 p1_ch_ok_next;
    logic [QD_W-1:0]      qd, rem_wide;
    logic [AW:0]          p2_rem_next;
    logic [AW-1:0]        p3_ipart_next;
    logic [AW-1:0]        base_rd, r0, r1;
    logic [MAW-1:0]       row, rd_addr0, rd_addr1, wr_addr;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   p5_prod_next;
    logic signed [ACC_W-1:0]    acc, y;
    logic [SAMPLE_W-1:0]  sat;
    logic [SAMPLE_W-1:0]  out_sample_next;

    // sample store
    logic [SAMPLE_W-1:0]  mem [TOTAL];

    // ---------------------------------------------------------------------
    // Handshake: each stage moves when it is empty or its successor moves
    // ---------------------------------------------------------------------
    assign rdy_o     = !out_valid_reg || m_tready;
    assign rdy5      = !p5_valid_reg || rdy_o;
    assign rdy4      = !p4_valid_reg || rdy5;
    assign rdy3      = !p3_valid_reg || rdy4;
    assign rdy2      = !p2_valid_reg || rdy3;
    assign rdy1      = !p1_valid_reg || rdy2;
    assign clear_done = (clr_cnt_reg == CLR_W'(TOTAL));
    assign s_tready  = rdy1 && clear_done;
    assign in_accept = s_tvalid && s_tready;
    // store access happens as an item leaves stage 3
    assign mem_go    = rdy4 && p3_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_ch_reg;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_ADDR_W-1:2] == REG_BASE_DELAY);

    always_comb
    begin
        // saturate into 1..BUFFER_DEPTH-1
        if (32'(pwdata[BASE_W-1:0]) > BUFFER_DEPTH - 1)
        begin
            base_delay_next = BASE_W'(BUFFER_DEPTH - 1);
        end
        else if (pwdata[BASE_W-1:0] == '0)
        begin
            base_delay_next = BASE_W'(1);
        end
        else
        begin
            base_delay_next = pwdata[BASE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[APB_ADDR_W-1:2] == REG_BASE_DELAY)
        begin
            prdata = APB_DATA_W'(base_delay_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1 input path: clamp, split, reciprocal multiply
    // ---------------------------------------------------------------------
    always_comb
    begin
        // negative offsets clamp to zero
        um = s_tdata[OFS_LSB+OFFSET_W-1] ? '0 : s_tdata[OFS_LSB+OFFSET_W-2:OFS_LSB];
        p1_v_next = um[OFFSET_W-2:FRAC_BITS];
        q_prod    = (2*IPW)'(p1_v_next) * (2*IPW)'(RECIP);
        p1_q_next = q_prod[2*IPW-1:IPW];
        p1_ch_ok_next = (32'(s_tuser) < CHANNELS);
    end

    // Stage 2: remainder of the estimate, below twice the depth
    always_comb
    begin
        qd          = QD_W'(p1_q_reg) * QD_W'(BUFFER_DEPTH);
        rem_wide    = QD_W'(p1_v_reg) - qd;
        p2_rem_next = rem_wide[AW:0];
    end

    // Stage 3: final correction
    always_comb
    begin
        if (p2_rem_reg >= (AW+1)'(BUFFER_DEPTH))
        begin
            p3_ipart_next = AW'(p2_rem_reg - (AW+1)'(BUFFER_DEPTH));
        end
        else
        begin
            p3_ipart_next = p2_rem_reg[AW-1:0];
        end
    end

    // Store addressing from the write pointer seen by this item
    always_comb
    begin
        base_rd  = sub_wrap(wp_reg, AW'(base_delay_reg));
        r0       = sub_wrap(base_rd, p3_ipart_reg);
        r1       = sub_wrap(r0, AW'(1));
        row      = p3_ch_ok_reg ? MAW'(p3_ch_reg) * MAW'(BUFFER_DEPTH) : '0;
        rd_addr0 = row + MAW'(r0);
        rd_addr1 = row + MAW'(r1);
        wr_addr  = row + MAW'(wp_reg);
        wp_next  = (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    end

    // Stage 5: s0*(1-f) + s1*f written as s0 + (s1-s0)*f
    always_comb
    begin
        diff         = $signed({p4_rd1_reg[SAMPLE_W-1], p4_rd1_reg}) -
                       $signed({p4_rd0_reg[SAMPLE_W-1], p4_rd0_reg});
        p5_prod_next = diff * $signed({1'b0, p4_frac_reg});
    end

    // Result: round half up, saturate; zero for a channel without a store row
    always_comb
    begin
        acc = (ACC_W'(p5_s0_reg) <<< FRAC_BITS) + ACC_W'(p5_prod_reg) +
              $signed(ACC_W'(1) << (FRAC_BITS - 1));
        y   = acc >>> FRAC_BITS;
        if ((&y[ACC_W-1:SAMPLE_W-1]) || !(|y[ACC_W-1:SAMPLE_W-1]))
        begin
            sat = y[SAMPLE_W-1:0];
        end
        else if (y[ACC_W-1])
        begin
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        out_sample_next = p5_ch_ok_reg ? sat : '0;
    end

    assign clr_cnt_next = clr_cnt_reg + CLR_W'(1);

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg <= BASE_DELAY_RST;
            wp_reg         <= '0;
            clr_cnt_reg    <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            p4_valid_reg   <= 1'b0;
            p5_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                base_delay_reg <= base_delay_next;
            end
            if (!clear_done)
            begin
                clr_cnt_reg <= clr_cnt_next;
            end
            if (mem_go && p3_fend_reg)
            begin
                wp_reg <= wp_next;
            end
            if (rdy1)  p1_valid_reg  <= in_accept;
            if (rdy2)  p2_valid_reg  <= p1_valid_reg;
            if (rdy3)  p3_valid_reg  <= p2_valid_reg;
            if (rdy4)  p4_valid_reg  <= p3_valid_reg;
            if (rdy5)  p5_valid_reg  <= p4_valid_reg;
            if (rdy_o) out_valid_reg <= p5_valid_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p1_ch_reg     <= s_tuser;
            p1_ch_ok_reg  <= p1_ch_ok_next;
            p1_sample_reg <= s_tdata[SAMPLE_W-1:0];
            p1_frac_reg   <= um[FRAC_BITS-1:0];
            p1_fend_reg   <= s_tlast;
            p1_v_reg      <= p1_v_next;
            p1_q_reg      <= p1_q_next;
        end
        if (rdy2)
        begin
            p2_ch_reg     <= p1_ch_reg;
            p2_ch_ok_reg  <= p1_ch_ok_reg;
            p2_sample_reg <= p1_sample_reg;
            p2_frac_reg   <= p1_frac_reg;
            p2_fend_reg   <= p1_fend_reg;
            p2_rem_reg    <= p2_rem_next;
        end
        if (rdy3)
        begin
            p3_ch_reg     <= p2_ch_reg;
            p3_ch_ok_reg  <= p2_ch_ok_reg;
            p3_sample_reg <= p2_sample_reg;
            p3_frac_reg   <= p2_frac_reg;
            p3_fend_reg   <= p2_fend_reg;
            p3_ipart_reg  <= p3_ipart_next;
        end
        if (rdy4)
        begin
            p4_ch_reg    <= p3_ch_reg;
            p4_ch_ok_reg <= p3_ch_ok_reg;
            p4_frac_reg  <= p3_frac_reg;
        end
        if (rdy5)
        begin
            p5_ch_reg    <= p4_ch_reg;
            p5_ch_ok_reg <= p4_ch_ok_reg;
            p5_s0_reg    <= $signed(p4_rd0_reg);
            p5_prod_reg  <= p5_prod_next;
        end
        if (rdy_o)
        begin
            out_sample_reg <= out_sample_next;
            out_ch_reg     <= p5_ch_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Sample store: two registered reads and one write per cycle.
    // Reads take the old contents when they hit the entry being written.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (!clear_done)
        begin
            mem[clr_cnt_reg[MAW-1:0]] <= '0;
        end
        else if (mem_go && p3_ch_ok_reg)
        begin
            mem[wr_addr] <= p3_sample_reg;
        end
        if (rdy4)
        begin
            p4_rd0_reg <= mem[rd_addr0];
            p4_rd1_reg <= mem[rd_addr1];
        end
    end

endmodule

### rtl/mfdl_chk.sv
// Port-level assertion checker for the modulated fractional delay line, with its bind.
module mfdl_chk #(
    parameter int CHANNELS = mfdl_pkg::CHANNELS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mfdl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [mfdl_pkg::CH_W-1:0]         m_tuser
);
    import mfdl_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // store sweep keeps the input closed right after reset
    a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input open during store sweep");

    // with no back-pressure a transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

    // channel without a store row yields silence
    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (32'(m_tuser) >= CHANNELS) |-> (m_tdata[SAMPLE_W-1:0] == '0))
        else $error("nonzero result for unused channel");

endmodule

bind modulated_fractional_delay_line mfdl_chk #(.CHANNELS(CHANNELS)) u_mfdl_chk (.*);
